@@ rtl/graph_reachability_dfs_assert.svh @@
// Assertion macros shared by the reachability block's checker.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef GRAPH_REACHABILITY_DFS_ASSERT_SVH
`define GRAPH_REACHABILITY_DFS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRD_ASSERT_SAME(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRD_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

@@ rtl/grd_pkg.sv @@
// Package for the graph reachability block: widths, FSM states and the
// command/status structs between controller and datapath. No dependencies.
package grd_pkg;

    localparam int ROWS      = 8;
    localparam int ROW_W     = 8;
    localparam int VIDX_W    = 3;
    localparam int ROOT_W    = 4;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QWALK,
        ST_SCAN,
        ST_RWALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_query;
        logic expand;
        logic capture_hit;
        logic seed_root;
        logic merge_root;
        logic next_vertex;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic front_zero;
        logic vert_marked;
        logic vert_last;
    } t_dp_stat;

endpackage

@@ rtl/grd_datapath.sv @@
// Datapath of the reachability block: adjacency rows, walk masks, root
// counter and result register. Uses grd_pkg; driven by grd_controller.
module grd_datapath import grd_pkg::*; #(
    parameter int VERTICES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data,
    input  logic [VIDX_W-1:0]    i_start,
    input  logic [VIDX_W-1:0]    i_target,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_reachable,
    output logic [ROOT_W-1:0]    o_root_count
);

    localparam logic [ROW_W-1:0] VMASK = ROW_W'((9'd1 << VERTICES) - 9'd1);
    localparam logic [VIDX_W-1:0] VLAST = VIDX_W'(VERTICES - 1);

    logic [ROW_W-1:0]  r_adj [ROWS];
    logic [ROW_W-1:0]  r_seen;
    logic [ROW_W-1:0]  r_front;
    logic [ROW_W-1:0]  r_marked;
    logic [VIDX_W-1:0] r_vidx;
    logic [VIDX_W-1:0] r_target;
    logic [ROOT_W-1:0] r_roots;
    logic              r_hit;
    logic              r_out_reach;
    logic [ROOT_W-1:0] r_out_roots;

    logic [ROW_W-1:0]  n_reach;
    logic [ROW_W-1:0]  query_seed;
    logic [ROW_W-1:0]  root_seed;

    // Gather successors of every frontier vertex
    always_comb begin
        n_reach = '0;
        for (int v = 0; v < ROWS; v++) begin
            if (r_front[v]) begin
                n_reach = n_reach | r_adj[v];
            end
        end
        n_reach = n_reach & VMASK;
    end

    // Start vertex outside the graph seeds nothing
    assign query_seed = (ROW_W'(1) << i_start) & VMASK;
    assign root_seed  = ROW_W'(1) << r_vidx;

    // Adjacency rows, cleared on reset and written from the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_adj[r] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(ROWS))) begin
            r_adj[i_cfg_index[VIDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Walk state and root scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_target <= i_target;
            r_seen   <= query_seed;
            r_front  <= query_seed;
            r_marked <= '0;
            r_vidx   <= '0;
            r_roots  <= '0;
        end
        if (i_cmd.expand) begin
            r_front <= n_reach & ~r_seen;
            r_seen  <= r_seen | n_reach;
        end
        if (i_cmd.capture_hit) begin
            r_hit <= r_seen[r_target];
        end
        if (i_cmd.seed_root) begin
            r_seen  <= root_seed;
            r_front <= root_seed;
            r_roots <= r_roots + ROOT_W'(1);
        end
        if (i_cmd.merge_root) begin
            r_marked <= r_marked | r_seen;
        end
        if (i_cmd.next_vertex) begin
            r_vidx <= r_vidx + VIDX_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_reach <= r_hit;
            r_out_roots <= r_roots;
        end
    end

    assign o_stat.front_zero  = (r_front == '0);
    assign o_stat.vert_marked = r_marked[r_vidx];
    assign o_stat.vert_last   = (r_vidx == VLAST);

    assign o_reachable  = r_out_reach;
    assign o_root_count = r_out_roots;

endmodule

@@ rtl/grd_controller.sv @@
// Controller FSM of the reachability block: sequences the query walk and
// the root scan, owns the request handshakes. Uses grd_pkg.
module grd_controller import grd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_query = 1'b1;
                    n_state          = ST_QWALK;
                end
            end
            ST_QWALK: begin
                if (i_stat.front_zero) begin
                    o_cmd.capture_hit = 1'b1;
                    n_state           = ST_SCAN;
                end else begin
                    o_cmd.expand = 1'b1;
                end
            end
            ST_SCAN: begin
                if (!i_stat.vert_marked) begin
                    o_cmd.seed_root = 1'b1;
                    n_state         = ST_RWALK;
                end else if (i_stat.vert_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.next_vertex = 1'b1;
                end
            end
            ST_RWALK: begin
                if (i_stat.front_zero) begin
                    o_cmd.merge_root = 1'b1;
                    if (i_stat.vert_last) begin
                        n_state = ST_FINISH;
                    end else begin
                        o_cmd.next_vertex = 1'b1;
                        n_state           = ST_SCAN;
                    end
                end else begin
                    o_cmd.expand = 1'b1;
                end
            end
            ST_FINISH: begin
                // Hold until the result register is free
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Raise valid on load, drop it when the result is taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/graph_reachability_dfs.sv @@
// Top level of the graph reachability block: adjacency-matrix walk with
// breadth-first forest root count. Uses grd_pkg, grd_controller, grd_datapath.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | query: start_vertex, target_vertex
//  m_axis    | out       | result: reachable, root_count
//  cfg       | in        | adjacency row write: index 0..7, 8-bit row
//
// A query loads, walks from the start vertex, then scans the vertices in
// order and walks from each unmarked one as a new root, merging its reach
// into the marks, and finishes by loading the result register; each walk
// advances one frontier step per cycle through the shared successor OR.
// Reset clears the FSM, the result valid and the adjacency rows.
// A stalled result holds in the output register while the next query is
// accepted; its finish waits for the register.
module graph_reachability_dfs import grd_pkg::*; #(
    parameter int VERTICES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [2:0] start_vertex, [5:3] target_vertex
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [0] reachable, [4:1] root_count
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data
);

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic              res_reach;
    logic [ROOT_W-1:0] res_roots;

    assign o_cfg_ready = 1'b1;

    grd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    grd_datapath #(
        .VERTICES (VERTICES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start      (s_axis_tdata[2:0]),
        .i_target     (s_axis_tdata[5:3]),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_reachable  (res_reach),
        .o_root_count (res_roots)
    );

    assign m_axis_tdata = {3'b000, res_roots, res_reach};

endmodule

@@ rtl/grd_checker.sv @@
// Port-level checker for graph_reachability_dfs, bound to the top level.
// Uses graph_reachability_dfs_assert.svh and grd_pkg.
`include "graph_reachability_dfs_assert.svh"

module grd_checker import grd_pkg::*; #(
    parameter int VERTICES = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [7:0]           s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata
);

    // Stalled result holds
    `GRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // One query at a time
    `GRD_ASSERT_NEXT(a_one_query, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second query accepted during walk")

    // Root count is nonzero and stays within the vertex count
    `GRD_ASSERT_SAME(a_root_range, m_axis_tvalid, (m_axis_tdata[4:1] != 4'd0) && (m_axis_tdata[4:1] <= 4'(VERTICES)), "root count out of range")

    // Pad bits stay clear
    `GRD_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:5] == 3'b000, "result pad bits set")

endmodule

bind graph_reachability_dfs grd_checker #(
    .VERTICES (VERTICES)
) u_grd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
